@@ src/nfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_pkg: shared types and constants for the Newton fractal pixel engine
// Fixed-point formats, register indexes, sequencer states and saturation.
// ----------------------------------------------------------------------------
package nfp_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 27;
   localparam int ITER_BITS  = 16;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // divider datapath width: holds |z|^2 shifted up for the quotient scaling
   localparam int DIV_BITS = (FRAC_BITS + 36 > 64) ? FRAC_BITS + 36 : 64;
   localparam int DIV_SHIFT = 32 - FRAC_BITS;
   localparam int QUO_BITS = 31;
   localparam int GRAY_BITS = 8;
   localparam int CNT_BITS = 5;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_X_ORIGIN = 3'd0,
      REG_Y_ORIGIN = 3'd1,
      REG_X_STEP   = 3'd2,
      REG_Y_STEP   = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_X, ST_Y, ST_Z,
      ST_SQR, ST_SQI, ST_XY, ST_CHK, ST_NEW,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
      ST_DSET, ST_DIV, ST_DFIN, ST_UPD
   } state_type;

   typedef enum logic [1:0] {
      PH_RE, PH_IM, PH_GRAY
   } phase_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000)
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

endpackage

@@ src/newton_fractal_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_fractal_pixel: Newton fractal escape-time engine, one pixel a command
// Maps a pixel to a start point and iterates z = z - (1+i)(z^2-1)/(2z).
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low; busy then stays high
// until the result is shown on the rsp_ ports for one cycle with rsp_valid.
// The receiver cannot stall, so results must be captured on that cycle.
// Each pixel runs setup, then one Newton iteration per pass until escape,
// then the finish (escape test and gray divide); busy stays high throughout
// and the result follows in the next cycle. Everything runs through one 32x32
// multiplier and one restoring divider (one quotient bit a cycle, 31 bits for
// each of the two quotient parts). Registers must be written through csr_
// only while the block is idle; the block itself does not enforce this.
module newton_fractal_pixel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [nfp_pkg::COORD_BITS-1:0]      req_col,
   input  logic [nfp_pkg::COORD_BITS-1:0]      req_row,
   input  logic                                csr_we,
   input  logic [nfp_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [nfp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                rsp_valid,
   output logic [nfp_pkg::COORD_BITS-1:0]      rsp_out_col,
   output logic [nfp_pkg::COORD_BITS-1:0]      rsp_out_row,
   output logic [nfp_pkg::ITER_BITS-1:0]       rsp_iterations,
   output logic [nfp_pkg::GRAY_BITS-1:0]       rsp_gray
);
   import nfp_pkg::*;

   localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

   // configuration
   logic signed [31:0]   x_origin_ff, y_origin_ff, x_step_ff, y_step_ff;
   logic [ITER_BITS-1:0] max_iter_ff;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   logic signed [31:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [31:0]    wr_ff, wr_in, wi_ff, wi_in;
   logic signed [31:0]    nr_ff, nr_in, ni_ff, ni_in;
   logic signed [31:0]    qr_ff, qr_in, qi_ff, qi_in;
   logic signed [63:0]    prod_ff, prod_in, acc_ff, acc_in;
   logic [63:0]           den_ff, den_in;
   logic signed [64:0]    numr_ff, numr_in, numi_ff, numi_in;

   // divider
   logic [DIV_BITS-1:0]   rem_ff, rem_in, dd_ff, dd_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in, steps_ff, steps_in;
   logic                  sat_ff, sat_in, neg_ff, neg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GRAY_BITS-1:0]  gray_ff, gray_in;

   logic signed [31:0]    mul_a, mul_b;
   logic signed [64:0]    num_sel, mag_full;
   logic [DIV_BITS-1:0]   mag_ext;
   logic [DIV_BITS:0]     rem2, rem_sub;
   logic                  rem_ge;
   logic [31:0]           qmag;
   logic signed [31:0]    qval;
   logic [ITER_BITS+7:0]  gray_num;
   logic                  escape;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= -32'sd536870912;
         y_origin_ff <= -32'sd536870912;
         x_step_ff   <= 32'sd1677722;
         y_step_ff   <= 32'sd2236962;
         max_iter_ff <= ITER_BITS'(100);
      end else if (csr_we) begin
         case (csr_addr)
            REG_X_ORIGIN: x_origin_ff <= csr_wdata;
            REG_Y_ORIGIN: y_origin_ff <= csr_wdata;
            REG_X_STEP:   x_step_ff   <= csr_wdata;
            REG_Y_STEP:   y_step_ff   <= csr_wdata;
            REG_MAX_ITER: max_iter_ff <= csr_wdata[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;   row_ff  <= row_in;   iter_ff <= iter_in;
      zr_ff    <= zr_in;    zi_ff   <= zi_in;
      wr_ff    <= wr_in;    wi_ff   <= wi_in;
      nr_ff    <= nr_in;    ni_ff   <= ni_in;
      qr_ff    <= qr_in;    qi_ff   <= qi_in;
      prod_ff  <= prod_in;  acc_ff  <= acc_in;  den_ff <= den_in;
      numr_ff  <= numr_in;  numi_ff <= numi_in;
      rem_ff   <= rem_in;   dd_ff   <= dd_in;   quo_ff <= quo_in;
      steps_ff <= steps_in; sat_ff  <= sat_in;  neg_ff <= neg_in;
      gray_ff  <= gray_in;
   end

   // the one multiplier, registered
   assign prod_in = mul_a * mul_b;

   // divider step and quotient finishing
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, dd_ff};
   assign rem_ge  = !rem_sub[DIV_BITS];
   assign qmag    = sat_ff ? 32'h8000_0000 : {1'b0, quo_ff};
   assign qval    = neg_ff ? -$signed(qmag)
                           : (sat_ff ? 32'sh7FFF_FFFF : $signed(qmag));

   assign num_sel  = (phase_ff == PH_RE) ? numr_ff : numi_ff;
   assign mag_full = num_sel[64] ? -num_sel : num_sel;
   assign mag_ext  = DIV_BITS'(mag_full[63:0]);
   assign gray_num = {iter_ff, 8'd0} - (ITER_BITS+8)'(iter_ff);
   assign escape   = ((den_ff >> (2*FRAC_BITS + 4)) != 64'd0)
                     || (iter_ff >= max_iter_ff) || (den_ff == 64'd0);

   always_comb begin
      state_in = state_ff;  phase_in = phase_ff;
      col_in = col_ff;  row_in = row_ff;  iter_in = iter_ff;
      zr_in = zr_ff;  zi_in = zi_ff;  wr_in = wr_ff;  wi_in = wi_ff;
      nr_in = nr_ff;  ni_in = ni_ff;  qr_in = qr_ff;  qi_in = qi_ff;
      acc_in = acc_ff;  den_in = den_ff;  numr_in = numr_ff;  numi_in = numi_ff;
      rem_in = rem_ff;  dd_in = dd_ff;  quo_in = quo_ff;  cnt_in = cnt_ff;
      steps_in = steps_ff;  sat_in = sat_ff;  neg_in = neg_ff;
      gray_in = gray_ff;  rsp_valid_in = 1'b0;
      mul_a = zr_ff;  mul_b = zr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in   = req_col;
               row_in   = req_row;
               state_in = ST_X;
            end
         end
         ST_X: begin
            mul_a    = 32'(col_ff);
            mul_b    = x_step_ff;
            state_in = ST_Y;
         end
         ST_Y: begin
            zr_in    = sat32(66'(x_origin_ff) + 66'(prod_ff));
            mul_a    = 32'(row_ff);
            mul_b    = y_step_ff;
            state_in = ST_Z;
         end
         ST_Z: begin
            zi_in    = sat32(66'(y_origin_ff) + 66'(prod_ff));
            iter_in  = '0;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            state_in = ST_SQI;
         end
         ST_SQI: begin
            acc_in   = prod_ff;
            mul_a    = zi_ff;
            mul_b    = zi_ff;
            state_in = ST_XY;
         end
         ST_XY: begin
            den_in   = acc_ff + prod_ff;
            acc_in   = acc_ff - prod_ff;
            mul_b    = zi_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // zr^2 - zi^2 sits in acc, zr*zi in prod
            if (escape) begin
               phase_in = PH_GRAY;
               state_in = ST_DSET;
            end else begin
               wr_in    = sat32(66'(acc_ff >>> FRAC_BITS) - ONE);
               wi_in    = sat32(66'(prod_ff >>> (FRAC_BITS - 1)));
               state_in = ST_NEW;
            end
         end
         ST_NEW: begin
            nr_in    = sat32(66'(wr_ff) - 66'(wi_ff));
            ni_in    = sat32(66'(wr_ff) + 66'(wi_ff));
            state_in = ST_P0;
         end
         ST_P0: begin
            mul_a    = nr_ff;
            state_in = ST_P1;
         end
         ST_P1: begin
            acc_in   = prod_ff;
            mul_a    = ni_ff;
            mul_b    = zi_ff;
            state_in = ST_P2;
         end
         ST_P2: begin
            numr_in  = 65'(acc_ff) + 65'(prod_ff);
            mul_a    = ni_ff;
            state_in = ST_P3;
         end
         ST_P3: begin
            acc_in   = prod_ff;
            mul_a    = nr_ff;
            mul_b    = zi_ff;
            state_in = ST_P4;
         end
         ST_P4: begin
            numi_in  = 65'(acc_ff) - 65'(prod_ff);
            phase_in = PH_RE;
            state_in = ST_DSET;
         end
         ST_DSET: begin
            cnt_in = '0;
            if (phase_ff == PH_GRAY) begin
               rem_in   = DIV_BITS'(gray_num);
               dd_in    = DIV_BITS'(max_iter_ff) << GRAY_BITS;
               steps_in = CNT_BITS'(GRAY_BITS);
               sat_in   = 1'b0;
               neg_in   = 1'b0;
            end else begin
               dd_in    = DIV_BITS'(den_ff) << DIV_SHIFT;
               rem_in   = mag_ext;
               steps_in = CNT_BITS'(QUO_BITS);
               sat_in   = mag_ext >= (DIV_BITS'(den_ff) << DIV_SHIFT);
               neg_in   = num_sel[64];
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = rem_ge ? rem_sub[DIV_BITS-1:0] : rem2[DIV_BITS-1:0];
            quo_in   = {quo_ff[QUO_BITS-2:0], rem_ge};
            cnt_in   = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == steps_ff - CNT_BITS'(1))
               state_in = ST_DFIN;
         end
         ST_DFIN: begin
            case (phase_ff)
               PH_RE: begin
                  qr_in    = qval;
                  phase_in = PH_IM;
                  state_in = ST_DSET;
               end
               PH_IM: begin
                  qi_in    = qval;
                  state_in = ST_UPD;
               end
               default: begin
                  gray_in      = (max_iter_ff == '0) ? '0 : quo_ff[GRAY_BITS-1:0];
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_UPD: begin
            zr_in    = sat32(66'(zr_ff) - 66'(qr_ff));
            zi_in    = sat32(66'(zi_ff) - 66'(qi_ff));
            iter_in  = iter_ff + ITER_BITS'(1);
            state_in = ST_SQR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_col    = col_ff;
   assign rsp_out_row    = row_ff;
   assign rsp_iterations = iter_ff;
   assign rsp_gray       = gray_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result shown while still busy");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < steps_ff))
      else $error("divider ran past its step count");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (iter_ff < max_iter_ff))
      else $error("iteration past limit");

endmodule
